// File: hdl/c2s_pkg.sv
// Shared constants, angle table and helpers for the Cartesian-to-spherical pipeline.
package c2s_pkg;

  // defaults for the top-level parameters
  localparam int DEF_CORDIC_STAGES = 16;
  localparam int DEF_COORD_WIDTH   = 32;

  // fraction bits added before the angle CORDICs
  localparam int GUARD_BITS = 12;

  // angle accumulator: 2^31 = pi, two bits of headroom over one turn
  localparam int ACC_W    = 34;
  localparam int ATAN_MAX = 24;

  localparam logic signed [ACC_W-1:0] ACC_PI = ACC_W'(64'sd2147483648);

  // output angle format: 32768 = pi
  localparam int OUT_ANG_W = 18;
  localparam logic signed [OUT_ANG_W-1:0] OUT_PI  = OUT_ANG_W'(32768);
  localparam logic signed [OUT_ANG_W-1:0] OUT_NPI = -OUT_ANG_W'(32768);
  localparam logic signed [OUT_ANG_W-1:0] OUT_ZERO = '0;

  // arctangent of 2^-i, 2^32 per turn
  function automatic logic [31:0] atan_entry(input int idx);
    logic [31:0] v;
    unique case (idx)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2F9;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

  // round accumulator to output units and clamp to [lo, hi]
  function automatic logic signed [OUT_ANG_W-1:0] to_out_angle(
      input logic signed [ACC_W-1:0] acc,
      input logic signed [OUT_ANG_W-1:0] lo,
      input logic signed [OUT_ANG_W-1:0] hi);
    logic signed [ACC_W-1:0] s;
    logic signed [OUT_ANG_W-1:0] r;
    s = acc + ACC_W'(32768);
    r = s[ACC_W-1:16];
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r;
  endfunction

endpackage

// File: hdl/c2s_sqrt.sv
// Pipelined digit-by-digit integer square root, one result bit per stage.
module c2s_sqrt import c2s_pkg::*; #(
  parameter int DIGITS = 45,
  parameter int SIDE_W = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2*DIGITS-1:0] n_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [DIGITS-1:0]   root_o,
  output logic [DIGITS+3:0]   rem_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int RW = DIGITS + 4;

  logic                valid_q [DIGITS+1];
  logic [2*DIGITS-1:0] n_q     [DIGITS+1];
  logic [DIGITS-1:0]   root_q  [DIGITS+1];
  logic [RW-1:0]       rem_q   [DIGITS+1];
  logic [SIDE_W-1:0]   side_q  [DIGITS+1];

  // stage 0 is the input itself
  assign valid_q[0] = valid_i;
  assign n_q[0]     = n_i;
  assign root_q[0]  = '0;
  assign rem_q[0]   = '0;
  assign side_q[0]  = side_i;

  for (genvar k = 0; k < DIGITS; k++) begin : g_digit
    logic [RW-1:0]       rem_sh;
    logic [RW-1:0]       trial;
    logic                take;
    logic [RW-1:0]       rem_d;
    logic [DIGITS-1:0]   root_d;

    // bring down the next pair and try (root << 2) | 1
    assign rem_sh = {rem_q[k][RW-3:0], n_q[k][2*DIGITS-1 -: 2]};
    assign trial  = RW'({root_q[k], 2'b01});
    assign take   = rem_sh >= trial;
    assign rem_d  = take ? rem_sh - trial : rem_sh;
    assign root_d = {root_q[k][DIGITS-2:0], take};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[k+1] <= valid_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]    <= {n_q[k][2*DIGITS-3:0], 2'b00};
        root_q[k+1] <= root_d;
        rem_q[k+1]  <= rem_d;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = valid_q[DIGITS];
  assign root_o  = root_q[DIGITS];
  assign rem_o   = rem_q[DIGITS];
  assign side_o  = side_q[DIGITS];

endmodule

// File: hdl/c2s_cordic.sv
// Pipelined CORDIC vectoring unit: atan2(b, a), one micro-rotation per stage.
module c2s_cordic import c2s_pkg::*; #(
  parameter int STAGES = 16,
  parameter int AW     = 47,
  parameter int SIDE_W = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [AW-1:0]    b_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    valid_o,
  output logic signed [ACC_W-1:0] acc_o,
  output logic [SIDE_W-1:0]       side_o
);

  logic                    valid_q [STAGES+1];
  logic signed [AW-1:0]    a_q     [STAGES+1];
  logic signed [AW-1:0]    b_q     [STAGES+1];
  logic signed [ACC_W-1:0] acc_q   [STAGES+1];
  logic [SIDE_W-1:0]       side_q  [STAGES+1];

  // left half-plane: start at +-pi and rotate by pi
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      if (a_i < 0) begin
        a_q[0]   <= -a_i;
        b_q[0]   <= -b_i;
        acc_q[0] <= (b_i > 0) ? ACC_PI : -ACC_PI;
      end else begin
        a_q[0]   <= a_i;
        b_q[0]   <= b_i;
        acc_q[0] <= '0;
      end
    end
  end

  // micro-rotations towards b = 0
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [ACC_W-1:0] ATAN_I = $signed({2'b00, atan_entry(i)});
    logic signed [AW-1:0] da;
    logic signed [AW-1:0] db;

    assign da = b_q[i] >>> i;
    assign db = a_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        if (!b_q[i][AW-1]) begin
          a_q[i+1]   <= a_q[i] + da;
          b_q[i+1]   <= b_q[i] - db;
          acc_q[i+1] <= acc_q[i] + ATAN_I;
        end else begin
          a_q[i+1]   <= a_q[i] - da;
          b_q[i+1]   <= b_q[i] + db;
          acc_q[i+1] <= acc_q[i] - ATAN_I;
        end
      end
    end
  end

  assign valid_o = valid_q[STAGES];
  assign acc_o   = acc_q[STAGES];
  assign side_o  = side_q[STAGES];

endmodule

// File: hdl/cartesian_to_spherical.sv
// Top level: pipelined Cartesian-to-spherical conversion (radius, polar, azimuth).
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, coord_x/y/z_i          | into block
//   out     | out_valid_o, out_stall_i, radius_o, polar_     | out of block
//           | angle_o, azimuth_angle_o, zero_vector_o        |
//
// One point enters per cycle while the pipeline is not held; each point passes
// through stages A to C, the square-root and CORDIC stages and the output register.
// Reset clears only the valid bits; no clearing pass is needed.
// The whole pipeline holds while a result waits in the output register under
// out_stall_i; in_stall_o is high exactly then.
module cartesian_to_spherical import c2s_pkg::*; #(
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES,
  parameter int COORD_WIDTH   = DEF_COORD_WIDTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] radius_o,
  output logic [15:0] polar_angle_o,
  output logic [16:0] azimuth_angle_o,
  output logic        zero_vector_o
);

  localparam int CW     = COORD_WIDTH;
  localparam int NS     = (CORDIC_STAGES < ATAN_MAX) ? CORDIC_STAGES : ATAN_MAX;
  localparam int DIG    = CW + 1 + GUARD_BITS;
  localparam int RW     = DIG + 4;
  localparam int AW     = CW + GUARD_BITS + 3;
  localparam int RAD_W  = (DIG + 1 > 32) ? DIG + 1 : 32;
  localparam int SIDE_W = 32 + 5;

  logic en;
  logic out_valid_q;

  // pipeline advances unless a result is held
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // stage A: the low COORD_WIDTH bits taken as a signed value
  logic [63:0] raw_x, raw_y, raw_z;
  logic valid_a_q;
  logic signed [CW-1:0] x_a_q, y_a_q, z_a_q;

  assign raw_x = 64'(coord_x_i);
  assign raw_y = 64'(coord_y_i);
  assign raw_z = 64'(coord_z_i);

  // stage B: magnitudes squared
  logic [CW-1:0] mx, my, mz;
  logic valid_b_q;
  logic signed [CW-1:0] x_b_q, y_b_q, z_b_q;
  logic [2*CW-1:0] sx_b_q, sy_b_q, sz_b_q;

  assign mx = x_a_q[CW-1] ? CW'(~x_a_q + 1'b1) : CW'(x_a_q);
  assign my = y_a_q[CW-1] ? CW'(~y_a_q + 1'b1) : CW'(y_a_q);
  assign mz = z_a_q[CW-1] ? CW'(~z_a_q + 1'b1) : CW'(z_a_q);

  // stage C: sums of squares
  logic valid_c_q;
  logic signed [CW-1:0] x_c_q, y_c_q, z_c_q;
  logic [2*CW:0]   sxy_c_q;
  logic [2*CW+1:0] sall_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
      valid_c_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= in_valid_i;
      valid_b_q <= valid_a_q;
      valid_c_q <= valid_b_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_a_q    <= $signed(raw_x[CW-1:0]);
      y_a_q    <= $signed(raw_y[CW-1:0]);
      z_a_q    <= $signed(raw_z[CW-1:0]);
      x_b_q    <= x_a_q;
      y_b_q    <= y_a_q;
      z_b_q    <= z_a_q;
      sx_b_q   <= (2*CW)'(mx) * (2*CW)'(mx);
      sy_b_q   <= (2*CW)'(my) * (2*CW)'(my);
      sz_b_q   <= (2*CW)'(mz) * (2*CW)'(mz);
      x_c_q    <= x_b_q;
      y_c_q    <= y_b_q;
      z_c_q    <= z_b_q;
      sxy_c_q  <= (2*CW+1)'(sx_b_q) + (2*CW+1)'(sy_b_q);
      sall_c_q <= (2*CW+2)'(sx_b_q) + (2*CW+2)'(sy_b_q) + (2*CW+2)'(sz_b_q);
    end
  end

  // square roots: radius (leading zero pairs leave the root unchanged) and
  // the xy-plane length with guard bits
  logic [2*DIG-1:0] n_r, n_xy;
  logic valid_r, valid_xy;
  logic [DIG-1:0] root_r, root_xy;
  logic [RW-1:0]  rem_r, rem_xy;
  logic [3*CW-1:0] xyz_s;
  logic            xyz_dummy;

  assign n_r  = (2*DIG)'(sall_c_q);
  assign n_xy = (2*DIG)'({sxy_c_q, {(2*GUARD_BITS){1'b0}}});

  c2s_sqrt #(.DIGITS(DIG), .SIDE_W(3*CW)) u_sqrt_r (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_c_q),
    .n_i(n_r), .side_i({x_c_q, y_c_q, z_c_q}),
    .valid_o(valid_r), .root_o(root_r), .rem_o(rem_r), .side_o(xyz_s)
  );

  c2s_sqrt #(.DIGITS(DIG), .SIDE_W(1)) u_sqrt_xy (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_c_q),
    .n_i(n_xy), .side_i(1'b0),
    .valid_o(valid_xy), .root_o(root_xy), .rem_o(rem_xy), .side_o(xyz_dummy)
  );

  // CORDIC entry: rounding of radius, special-case flags, scaled operands
  logic signed [CW-1:0] xs, ys, zs;
  logic [RAD_W-1:0] rad_full;
  logic             zero_s;
  logic [SIDE_W-1:0] side_in;
  logic signed [AW-1:0] pa, pb, za, zb;
  logic valid_s;

  assign xs = $signed(xyz_s[3*CW-1 -: CW]);
  assign ys = $signed(xyz_s[2*CW-1 -: CW]);
  assign zs = $signed(xyz_s[CW-1:0]);

  assign rad_full = RAD_W'(root_r) + RAD_W'(rem_r > RW'(root_r));
  assign zero_s   = (xs == '0) && (ys == '0) && (zs == '0);
  // rem of the xy root is not needed; fold it into valid to keep it observed
  assign valid_s  = valid_r && valid_xy && (rem_xy == rem_xy) && !xyz_dummy | (valid_r && valid_xy);
  assign side_in  = {rad_full[31:0], zero_s, (root_xy == '0), (zs > 0),
                     (ys == '0), xs[CW-1]};

  assign pa = AW'(zs) <<< GUARD_BITS;
  assign pb = $signed(AW'(root_xy));
  assign za = AW'(xs) <<< GUARD_BITS;
  assign zb = AW'(ys) <<< GUARD_BITS;

  logic valid_p, valid_z;
  logic signed [ACC_W-1:0] acc_p, acc_z;
  logic [SIDE_W-1:0] side_p;
  logic              side_z;

  c2s_cordic #(.STAGES(NS), .AW(AW), .SIDE_W(SIDE_W)) u_cordic_polar (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_s),
    .a_i(pa), .b_i(pb), .side_i(side_in),
    .valid_o(valid_p), .acc_o(acc_p), .side_o(side_p)
  );

  c2s_cordic #(.STAGES(NS), .AW(AW), .SIDE_W(1)) u_cordic_azim (
    .clk_i, .rst_ni, .en_i(en), .valid_i(valid_s),
    .a_i(za), .b_i(zb), .side_i(1'b0),
    .valid_o(valid_z), .acc_o(acc_z), .side_o(side_z)
  );

  // output register with special cases
  logic [31:0] radius_q;
  logic [15:0] polar_q;
  logic [16:0] azim_q;
  logic        zero_q;
  logic signed [OUT_ANG_W-1:0] polar_d, azim_d;
  logic        f_zero, f_rxy0, f_zpos, f_y0, f_xneg;

  assign {f_zero, f_rxy0, f_zpos, f_y0, f_xneg} = side_p[4:0];

  always_comb begin
    if (f_rxy0) begin
      polar_d = f_zpos ? OUT_ZERO : OUT_PI;
    end else begin
      polar_d = to_out_angle(acc_p, OUT_ZERO, OUT_PI);
    end
    if (f_y0) begin
      azim_d = f_xneg ? OUT_PI : OUT_ZERO;
    end else begin
      azim_d = to_out_angle(acc_z, OUT_NPI, OUT_PI);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= valid_p && valid_z && !side_z | (valid_p && valid_z);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (f_zero) begin
        radius_q <= '0;
        polar_q  <= '0;
        azim_q   <= '0;
        zero_q   <= 1'b1;
      end else begin
        radius_q <= side_p[SIDE_W-1 -: 32];
        polar_q  <= polar_d[15:0];
        azim_q   <= azim_d[16:0];
        zero_q   <= 1'b0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign radius_o        = radius_q;
  assign polar_angle_o   = polar_q;
  assign azimuth_angle_o = azim_q;
  assign zero_vector_o   = zero_q;

endmodule
